@@ rtl/core/pyts_pkg.sv @@
// ----------------------------------------------------------------------------
// Pitman-Yor table seating package
// Request and status codes, register indexes and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package pyts_pkg;

    localparam int REQ_ADD    = 0;
    localparam int REQ_REMOVE = 1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic REG_STRENGTH = 1'b0;
    localparam logic REG_DISCOUNT = 1'b1;

    localparam int STRENGTH_W = 26;
    localparam int DISCOUNT_W = 16;
    localparam int CFG_DATA_W = 26;
    localparam int PTABLES_W  = 20;
    localparam int PPROB_W    = 17;
    localparam int RAND_W     = 16;
    localparam int CUST_W     = 32;
    localparam int CHOSEN_W   = 8;
    localparam int TABLES_W   = 9;
    localparam int STATUS_W   = 2;

endpackage

@@ rtl/core/pyts_in_if.sv @@
// ----------------------------------------------------------------------------
// Pitman-Yor request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface pyts_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [19:0] parent_tables;
    logic [16:0] parent_prob;
    logic [15:0] rand_value;

    modport source (output valid, output req_type, output parent_tables,
                    output parent_prob, output rand_value, input ready);
    modport sink   (input valid, input req_type, input parent_tables,
                    input parent_prob, input rand_value, output ready);
endinterface

@@ rtl/core/pyts_out_if.sv @@
// ----------------------------------------------------------------------------
// Pitman-Yor result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface pyts_out_if;
    logic        valid;
    logic        ready;
    logic        table_changed;
    logic [7:0]  chosen_table;
    logic [31:0] customers_now;
    logic [8:0]  tables_now;
    logic [1:0]  status;

    modport source (output valid, output table_changed, output chosen_table,
                    output customers_now, output tables_now, output status,
                    input ready);
    modport sink   (input valid, input table_changed, input chosen_table,
                    input customers_now, input tables_now, input status,
                    output ready);
endinterface

@@ rtl/core/pitman_yor_table_seating_core.sv @@
// ----------------------------------------------------------------------------
// Pitman-Yor table seating core
// Keeps the table counts of one restaurant and seats or removes customers.
// ----------------------------------------------------------------------------
// The table counts live in a single-port-read, single-port-write memory and
// every request on a non-empty restaurant walks it one entry per cycle. An
// add first computes its threshold in the states S_MUL1, S_MUL2, S_DEN and
// S_THR, a remove in S_RTHR alone; a remove that empties a table then moves
// the tables behind it down one place. Adding to an empty restaurant or
// removing from one skips the walk. A new request word is taken while the
// previous result word still waits at the output.
module pitman_yor_table_seating_core #(
    parameter int MAX_TABLES = 256,
    parameter int COUNT_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [pyts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pyts_in_if.sink                    in_chan,
    pyts_out_if.source                 out_chan
);
    import pyts_pkg::*;

    localparam int IDX_W   = $clog2(MAX_TABLES);
    localparam int TT_W    = $clog2(MAX_TABLES + 1);
    localparam int EXT_W   = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam int P1_W    = DISCOUNT_W + PTABLES_W;
    localparam int SUM_W   = P1_W + 1;
    localparam int P2_W    = SUM_W + PPROB_W;
    localparam int B_W     = DISCOUNT_W + TT_W;
    localparam int DEN_W   = CUST_W + 17;
    localparam int THR_W   = DEN_W + 1;
    localparam int CUM_W   = (((48 + TT_W) > THR_W) ? (48 + TT_W) : THR_W) + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_MUL2  = 9'b000000100,
        S_DEN   = 9'b000001000,
        S_THR   = 9'b000010000,
        S_RTHR  = 9'b000100000,
        S_WALK  = 9'b001000000,
        S_UPD   = 9'b010000000,
        S_SHIFT = 9'b100000000
    } state_t;

    logic [COUNT_BITS-1:0] mem [MAX_TABLES];
    logic [COUNT_BITS-1:0] mem_rd_reg;
    logic                  mem_re, mem_we;
    logic [IDX_W-1:0]      mem_ra, mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic [STRENGTH_W-1:0] strength_reg;
    logic [DISCOUNT_W-1:0] discount_reg;
    logic                  req_reg, req_next;
    logic [PTABLES_W-1:0]  th_reg, th_next;
    logic [PPROB_W-1:0]    p_reg, p_next;
    logic [RAND_W-1:0]     r_reg, r_next;
    logic [CUST_W-1:0]     cust_reg, cust_next;
    logic [TT_W-1:0]       tot_reg, tot_next;
    logic [P1_W-1:0]       prod1_reg, prod1_next;
    logic [B_W-1:0]        b_reg, b_next;
    logic [P2_W-1:0]       prod2_reg, prod2_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [THR_W-1:0]      thr_reg, thr_next;
    logic [TT_W-1:0]       iss_reg, iss_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [TT_W-1:0]       pend_idx_reg, pend_idx_next;
    logic signed [CUM_W-1:0] cum_reg, cum_next;
    logic [TT_W-1:0]       k_reg, k_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic                  res_changed_reg, res_changed_next;
    logic [TT_W-1:0]       res_table_reg, res_table_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_vld_reg;
    logic                  out_changed_reg;
    logic [CHOSEN_W-1:0]   out_table_reg;
    logic [CUST_W-1:0]     out_cust_reg;
    logic [TABLES_W-1:0]   out_tables_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic                  in_acc;
    logic                  out_free;
    logic [EXT_W-1:0]      cnt_ext;
    logic [31:0]           cnt_sat;
    logic [DISCOUNT_W-1:0] disc_term;
    logic signed [CUM_W-1:0] term, cum_new, thr_s;
    logic                  hit;
    logic [SUM_W-1:0]      sum_w;
    logic [DEN_W-1:0]      a_w;
    logic [COUNT_BITS-1:0] new_cnt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_ra];
        end
    end

    assign in_acc   = in_chan.valid && in_chan.ready;
    assign out_free = !out_vld_reg || out_chan.ready;
    assign in_chan.ready = (state_reg == S_IDLE) && !done_reg;

    assign cnt_ext   = EXT_W'(mem_rd_reg);
    assign cnt_sat   = (cnt_ext > EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cnt_ext[31:0];
    assign disc_term = req_reg ? '0 : discount_reg;
    assign term      = signed'(CUM_W'({cnt_sat, 16'h0000})) - signed'(CUM_W'(disc_term));
    assign cum_new   = cum_reg + term;
    assign thr_s     = signed'(CUM_W'(thr_reg));
    assign hit       = cum_new >= thr_s;
    assign sum_w     = SUM_W'(strength_reg) + SUM_W'(prod1_reg);
    assign a_w       = DEN_W'({cust_reg, 16'h0000}) + DEN_W'(prod2_reg >> 16);
    assign new_cnt   = req_reg ? (hit_cnt_reg - 1'b1) : (hit_cnt_reg + 1'b1);

    always_comb
    begin
        state_next       = state_reg;
        done_next        = done_reg;
        req_next         = req_reg;
        th_next          = th_reg;
        p_next           = p_reg;
        r_next           = r_reg;
        cust_next        = cust_reg;
        tot_next         = tot_reg;
        prod1_next       = prod1_reg;
        b_next           = b_reg;
        prod2_next       = prod2_reg;
        den_next         = den_reg;
        thr_next         = thr_reg;
        iss_next         = iss_reg;
        pend_vld_next    = 1'b0;
        pend_idx_next    = pend_idx_reg;
        cum_next         = cum_reg;
        k_next           = k_reg;
        hit_cnt_next     = hit_cnt_reg;
        res_changed_next = res_changed_reg;
        res_table_next   = res_table_reg;
        res_status_next  = res_status_reg;
        mem_re           = 1'b0;
        mem_ra           = iss_reg[IDX_W-1:0];
        mem_we           = 1'b0;
        mem_wa           = k_reg[IDX_W-1:0];
        mem_wd           = new_cnt;

        if (done_reg && out_free)
        begin
            done_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next         = in_chan.req_type;
                    th_next          = in_chan.parent_tables;
                    p_next           = in_chan.parent_prob;
                    r_next           = in_chan.rand_value;
                    iss_next         = '0;
                    cum_next         = '0;
                    res_changed_next = 1'b0;
                    res_table_next   = '0;
                    res_status_next  = STATUS_OK;
                    if (in_chan.req_type == 1'(REQ_REMOVE))
                    begin
                        if (tot_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            state_next = S_RTHR;
                        end
                    end
                    else if (tot_reg == '0)
                    begin
                        mem_we           = 1'b1;
                        mem_wa           = '0;
                        mem_wd           = COUNT_BITS'(1);
                        tot_next         = TT_W'(1);
                        cust_next        = cust_reg + 1'b1;
                        res_changed_next = 1'b1;
                        done_next        = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                prod1_next = P1_W'(discount_reg * th_reg);
                b_next     = B_W'(discount_reg * tot_reg);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod2_next = P2_W'(sum_w * p_reg);
                state_next = S_DEN;
            end
            S_DEN:
            begin
                den_next   = (a_w > DEN_W'(b_reg)) ? (a_w - DEN_W'(b_reg)) : '0;
                state_next = S_THR;
            end
            S_THR:
            begin
                thr_next   = THR_W'((den_reg >> 16) * r_reg)
                           + THR_W'((den_reg[15:0] * r_reg) >> 16);
                state_next = S_WALK;
            end
            S_RTHR:
            begin
                thr_next   = THR_W'(r_reg * cust_reg);
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (iss_reg < tot_reg)
                begin
                    mem_re        = 1'b1;
                    iss_next      = iss_reg + 1'b1;
                    pend_vld_next = 1'b1;
                    pend_idx_next = iss_reg;
                end
                if (pend_vld_reg)
                begin
                    cum_next = cum_new;
                    if (hit || (req_reg && (pend_idx_reg == tot_reg - 1'b1)))
                    begin
                        k_next        = pend_idx_reg;
                        hit_cnt_next  = mem_rd_reg;
                        pend_vld_next = 1'b0;
                        state_next    = S_UPD;
                    end
                    else if (pend_idx_reg == tot_reg - 1'b1)
                    begin
                        if (tot_reg == TT_W'(MAX_TABLES))
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            mem_wa           = tot_reg[IDX_W-1:0];
                            mem_wd           = COUNT_BITS'(1);
                            tot_next         = tot_reg + 1'b1;
                            cust_next        = cust_reg + 1'b1;
                            res_changed_next = 1'b1;
                            res_table_next   = tot_reg;
                        end
                        pend_vld_next = 1'b0;
                        done_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_UPD:
            begin
                mem_we         = 1'b1;
                res_table_next = k_reg;
                if (req_reg)
                begin
                    cust_next = cust_reg - 1'b1;
                end
                else
                begin
                    cust_next = cust_reg + 1'b1;
                end
                if (req_reg && (new_cnt == '0))
                begin
                    tot_next         = tot_reg - 1'b1;
                    res_changed_next = 1'b1;
                    iss_next         = k_reg + 1'b1;
                    state_next       = S_SHIFT;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                if (iss_reg <= tot_reg)
                begin
                    mem_re        = 1'b1;
                    iss_next      = iss_reg + 1'b1;
                    pend_vld_next = 1'b1;
                    pend_idx_next = iss_reg;
                end
                if (pend_vld_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = IDX_W'(pend_idx_reg - 1'b1);
                    mem_wd = mem_rd_reg;
                end
                if (!(iss_reg <= tot_reg) && !pend_vld_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            strength_reg <= STRENGTH_W'(65536);
            discount_reg <= DISCOUNT_W'(32768);
            cust_reg     <= '0;
            tot_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            cust_reg     <= cust_next;
            tot_reg      <= tot_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STRENGTH: strength_reg <= cfg_wdata[STRENGTH_W-1:0];
                    REG_DISCOUNT: discount_reg <= cfg_wdata[DISCOUNT_W-1:0];
                    default:      strength_reg <= strength_reg;
                endcase
            end
            if (done_reg && out_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        th_reg          <= th_next;
        p_reg           <= p_next;
        r_reg           <= r_next;
        prod1_reg       <= prod1_next;
        b_reg           <= b_next;
        prod2_reg       <= prod2_next;
        den_reg         <= den_next;
        thr_reg         <= thr_next;
        iss_reg         <= iss_next;
        pend_idx_reg    <= pend_idx_next;
        cum_reg         <= cum_next;
        k_reg           <= k_next;
        hit_cnt_reg     <= hit_cnt_next;
        res_changed_reg <= res_changed_next;
        res_table_reg   <= res_table_next;
        res_status_reg  <= res_status_next;
        if (done_reg && out_free)
        begin
            out_changed_reg <= res_changed_reg;
            out_table_reg   <= CHOSEN_W'(res_table_reg);
            out_cust_reg    <= cust_reg;
            out_tables_reg  <= TABLES_W'(tot_reg);
            out_status_reg  <= res_status_reg;
        end
    end

    assign out_chan.valid         = out_vld_reg;
    assign out_chan.table_changed = out_changed_reg;
    assign out_chan.chosen_table  = out_table_reg;
    assign out_chan.customers_now = out_cust_reg;
    assign out_chan.tables_now    = out_tables_reg;
    assign out_chan.status        = out_status_reg;

endmodule

@@ bench/pyts_bench_pkg.sv @@
// ----------------------------------------------------------------------------
// Pitman-Yor seating bench package
// Request and result word types used by the checker.
// ----------------------------------------------------------------------------
package pyts_bench_pkg;

    typedef struct packed {
        logic        req_type;
        logic [19:0] parent_tables;
        logic [16:0] parent_prob;
        logic [15:0] rand_value;
    } request_t;

    typedef struct packed {
        logic        table_changed;
        logic [7:0]  chosen_table;
        logic [31:0] customers_now;
        logic [8:0]  tables_now;
        logic [1:0]  status;
    } result_t;

endpackage

@@ bench/seating_checker.sv @@
// ----------------------------------------------------------------------------
// Pitman-Yor seating checker
// Watches the configuration port and both channels, keeps its own copy of
// the restaurant, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module seating_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [pyts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pyts_in_if                              in_chan,
    pyts_out_if                             out_chan,
    output int                              mismatches,
    output int                              pending,
    output int                              tables_open
);
    import pyts_pkg::*;
    import pyts_bench_pkg::*;

    logic [31:0] seat_counts [256];
    logic [31:0] customer_total;
    int          table_total;
    logic [25:0] strength;
    logic [15:0] discount;
    result_t     expected_words [$];

    assign pending     = expected_words.size();
    assign tables_open = table_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic result_t make_word(logic chg, int tbl, logic [1:0] st);
        result_t w;
        w.table_changed = chg;
        w.chosen_table  = tbl[7:0];
        w.customers_now = customer_total;
        w.tables_now    = table_total[8:0];
        w.status        = st;
        return w;
    endfunction

    function automatic logic [63:0] sat(logic [31:0] v);
        return {32'd0, v};
    endfunction

    function automatic result_t seat_customer(request_t q);
        logic [63:0] a, b, den, thr;
        longint      cum;
        int          t;
        t = table_total;
        if (t == 0) begin
            seat_counts[0] = 1;
            table_total = 1;
            customer_total++;
            return make_word(1'b1, 0, STATUS_OK);
        end
        a = ({32'd0, customer_total} << 16)
            + ((({38'd0, strength} + {48'd0, discount} * {44'd0, q.parent_tables})
                * {47'd0, q.parent_prob}) >> 16);
        b = {48'd0, discount} * t;
        den = (a > b) ? a - b : 64'd0;
        thr = (den >> 16) * q.rand_value + (((den & 64'hFFFF) * q.rand_value) >> 16);
        cum = 0;
        for (int i = 0; i < t; i++) begin
            cum += longint'(sat(seat_counts[i]) << 16) - longint'(discount);
            if (cum >= longint'(thr)) begin
                seat_counts[i]++;
                customer_total++;
                return make_word(1'b0, i, STATUS_OK);
            end
        end
        if (t >= 256)
            return make_word(1'b0, 0, STATUS_FULL);
        seat_counts[t] = 1;
        table_total = t + 1;
        customer_total++;
        return make_word(1'b1, t, STATUS_OK);
    endfunction

    function automatic result_t unseat_customer(request_t q);
        logic [63:0] thr, cum;
        int          t, k;
        t = table_total;
        if (t == 0)
            return make_word(1'b0, 0, STATUS_EMPTY);
        thr = {48'd0, q.rand_value} * customer_total;
        cum = 0;
        k = t - 1;
        for (int i = 0; i < t; i++) begin
            cum += sat(seat_counts[i]) << 16;
            if (cum >= thr) begin
                k = i;
                break;
            end
        end
        customer_total--;
        seat_counts[k]--;
        if (seat_counts[k] == 0) begin
            for (int i = k; i + 1 < t; i++)
                seat_counts[i] = seat_counts[i + 1];
            table_total = t - 1;
            return make_word(1'b1, k, STATUS_OK);
        end
        return make_word(1'b0, k, STATUS_OK);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        request_t q;
        result_t  got, want;
        if (!rst_n) begin
            customer_total = 0;
            table_total    = 0;
            strength       = 26'd65536;
            discount       = 16'd32768;
            mismatches     = 0;
            expected_words.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_STRENGTH)
                    strength = cfg_wdata[25:0];
                else
                    discount = cfg_wdata[15:0];
            end
            if (in_chan.valid && in_chan.ready) begin
                q = {in_chan.req_type, in_chan.parent_tables, in_chan.parent_prob,
                     in_chan.rand_value};
                if (q.req_type == REQ_ADD[0])
                    expected_words.push_back(seat_customer(q));
                else
                    expected_words.push_back(unseat_customer(q));
            end
            if (out_chan.valid && out_chan.ready) begin
                got = {out_chan.table_changed, out_chan.chosen_table,
                       out_chan.customers_now, out_chan.tables_now, out_chan.status};
                if (expected_words.size() == 0) begin
                    $display("result word with nothing expected");
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.table_changed !== want.table_changed)
                        report_mismatch("table_changed", got.table_changed,
                                        want.table_changed);
                    if (got.chosen_table !== want.chosen_table)
                        report_mismatch("chosen_table", got.chosen_table,
                                        want.chosen_table);
                    if (got.customers_now !== want.customers_now)
                        report_mismatch("customers_now", got.customers_now,
                                        want.customers_now);
                    if (got.tables_now !== want.tables_now)
                        report_mismatch("tables_now", got.tables_now, want.tables_now);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
        end
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Pitman-Yor seating testbench
// Drives directed and random add and remove requests under several idling
// patterns and register settings, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
    import pyts_pkg::*;
    import pyts_bench_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    mismatches, pending, tables_open;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_off = 0;
    int                    quiet_cycles = 0;

    pyts_in_if  in_chan ();
    pyts_out_if out_chan ();

    pitman_yor_table_seating_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_chan(in_chan.sink), .out_chan(out_chan.source)
    );

    seating_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_chan(in_chan), .out_chan(out_chan),
        .mismatches(mismatches), .pending(pending), .tables_open(tables_open)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        in_chan.valid = 1'b0;
        in_chan.req_type = 1'b0;
        in_chan.parent_tables = '0;
        in_chan.parent_prob = '0;
        in_chan.rand_value = '0;
        out_chan.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_chan.ready <= 1'b0;
        end
        else
            out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** pitman_yor_table_seating_core: FAILED **");
            $finish;
        end
    end

    task automatic send_word(input logic kind, input logic [19:0] pt,
                             input logic [16:0] pp, input logic [15:0] rv);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_chan.valid <= 1'b1;
        in_chan.req_type <= kind;
        in_chan.parent_tables <= pt;
        in_chan.parent_prob <= pp;
        in_chan.rand_value <= rv;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        in_chan.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(input int add_pct);
        logic [16:0] pp;
        pp = ($urandom_range(9) == 0) ? 17'd65536 : 17'($urandom_range(65535));
        if (tables_open >= 250 && $urandom_range(1))
            send_word(REQ_REMOVE[0], 20'($urandom), pp, 16'($urandom));
        else
            send_word(($urandom_range(99) < add_pct) ? REQ_ADD[0] : REQ_REMOVE[0],
                      20'($urandom), pp, 16'($urandom));
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(REQ_REMOVE[0], 20'd0, 17'd0, 16'd0);
        send_word(REQ_ADD[0], 20'hFFFFF, 17'd65536, 16'hFFFF);
        send_word(REQ_ADD[0], 20'd0, 17'd0, 16'd0);
        send_word(REQ_ADD[0], 20'hFFFFF, 17'd65536, 16'hFFFF);
        send_word(REQ_ADD[0], 20'd1, 17'd1, 16'h8000);
        send_word(REQ_REMOVE[0], 20'hFFFFF, 17'h1FFFF, 16'hFFFF);
        send_word(REQ_REMOVE[0], 20'd0, 17'd0, 16'd0);
        send_word(REQ_REMOVE[0], 20'd0, 17'd0, 16'h4000);
        send_word(REQ_REMOVE[0], 20'd0, 17'd0, 16'hFFFF);
        send_word(REQ_REMOVE[0], 20'd0, 17'd0, 16'd0);
        drain();

        write_reg(REG_STRENGTH, 26'h3FFFFFF);
        write_reg(REG_DISCOUNT, 16'd0);
        // A huge strength opens a new table on almost every add: fill the store.
        for (int i = 0; i < 260; i++)
            send_word(REQ_ADD[0], 20'hFFFFF, 17'd65536, 16'hFFFF);
        drain();

        hold_off = 400;
        for (int i = 0; i < 40; i++)
            send_random(50);
        drain();

        write_reg(REG_STRENGTH, 26'd0);
        write_reg(REG_DISCOUNT, 16'hFFFF);
        for (int i = 0; i < 150; i++)
            send_random(40);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 11 : 71) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 11 : 71) : 0;
            write_reg(REG_STRENGTH, 26'($urandom_range(26'h3FFFFFF >> (2 * phase))));
            write_reg(REG_DISCOUNT, 16'($urandom));
            for (int i = 0; i < 160; i++)
                send_random((i < 80) ? 65 : 35);
            drain();
        end

        if (mismatches == 0)
            $display("** pitman_yor_table_seating_core: PASSED **");
        else
            $display("** pitman_yor_table_seating_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pyts_pkg.sv
rtl/core/pyts_in_if.sv
rtl/core/pyts_out_if.sv
rtl/core/pitman_yor_table_seating_core.sv
bench/pyts_bench_pkg.sv
bench/seating_checker.sv
bench/testbench.sv
